@@ sv/mer_pkg.sv @@
// ----------------------------------------------------------------------------
// mer_pkg: shared definitions for the midpoint ellipse rasteriser
// Default widths, stream packing, register indexes and the command and
// status bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package mer_pkg;

    localparam int COORD_BITS_DEF = 11;
    localparam int AXIS_BITS_DEF  = 10;

    // Each output coordinate is a 13-bit two's complement value.
    localparam int OUT_W        = 13;
    localparam int OUT_TDATA_W  = ((4 * OUT_W + 7) / 8) * 8;
    localparam int IN_TDATA_W   = 8;

    localparam int CFG_ADDR_W   = 2;
    localparam logic [CFG_ADDR_W-1:0] CFG_CENTER_X    = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_CENTER_Y    = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_SEMI_AXIS_X = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_SEMI_AXIS_Y = 2'd3;

    // Multiplier operations in issue order: four for the seed, four for the
    // recomputation of the decision value on entry to region two.
    typedef enum logic [2:0] {
        MUL_AA,
        MUL_BB,
        MUL_A4B,
        MUL_A4B2,
        MUL_TXTX,
        MUL_TYTY,
        MUL_B2TX2,
        MUL_A4TY2
    } t_mul_op;

    typedef struct packed {
        logic    seed;
        logic    mul_issue;
        logic    mul_wb;
        t_mul_op op;
        logic    emit;
        logic    region_two;
    } t_dp_cmd;

    typedef struct packed {
        logic py_gt_px;
        logic y_zero;
        logic out_free;
    } t_dp_status;

endpackage

@@ sv/mer_controller.sv @@
// ----------------------------------------------------------------------------
// mer_controller: sequencing state machine for the ellipse walk
// Accepts one word at a time, runs the seed and region-change multiplier
// sequences, and tells the datapath when to emit a point and step.
// ----------------------------------------------------------------------------
module mer_controller (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic                i_restart,
    input  mer_pkg::t_dp_status i_status,
    output mer_pkg::t_dp_cmd    o_cmd
);

    typedef enum logic [2:0] {
        S_READY,
        S_SEED,
        S_MUL,
        S_WB,
        S_CHECK,
        S_EMIT
    } t_state;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_ONE,
        PH_TWO,
        PH_DONE
    } t_phase;

    t_state           r_state;
    t_phase           r_phase;
    mer_pkg::t_mul_op r_op;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_READY;
            r_phase <= PH_IDLE;
            r_op    <= mer_pkg::MUL_AA;
        end else begin
            unique case (r_state)
                S_READY: begin
                    if (i_in_valid) begin
                        r_state <= i_restart ? S_SEED : S_CHECK;
                    end
                end
                S_SEED: begin
                    r_op    <= mer_pkg::MUL_AA;
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_state <= S_WB;
                end
                S_WB: begin
                    priority if (r_op == mer_pkg::MUL_A4B2) begin
                        r_phase <= PH_ONE;
                        r_state <= S_CHECK;
                    end else if (r_op == mer_pkg::MUL_A4TY2) begin
                        r_state <= S_EMIT;
                    end else begin
                        r_op    <= mer_pkg::t_mul_op'(r_op + 3'd1);
                        r_state <= S_MUL;
                    end
                end
                S_CHECK: begin
                    priority if (r_phase == PH_IDLE || r_phase == PH_DONE) begin
                        r_state <= S_READY;
                    end else if (r_phase == PH_ONE && !i_status.py_gt_px) begin
                        r_phase <= PH_TWO;
                        r_op    <= mer_pkg::MUL_TXTX;
                        r_state <= S_MUL;
                    end else begin
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (i_status.out_free) begin
                        if (r_phase == PH_TWO && i_status.y_zero) begin
                            r_phase <= PH_DONE;
                        end
                        r_state <= S_READY;
                    end
                end
                default: begin
                    r_state <= S_READY;
                end
            endcase
        end
    end

    assign o_in_ready = (r_state == S_READY);

    always_comb begin
        o_cmd            = '0;
        o_cmd.op         = r_op;
        o_cmd.seed       = (r_state == S_SEED);
        o_cmd.mul_issue  = (r_state == S_MUL);
        o_cmd.mul_wb     = (r_state == S_WB);
        o_cmd.emit       = (r_state == S_EMIT) && i_status.out_free;
        o_cmd.region_two = (r_phase == PH_TWO);
    end

endmodule

@@ sv/mer_datapath.sv @@
// ----------------------------------------------------------------------------
// mer_datapath: registers, shared multiplier and step arithmetic
// Holds the configuration, the walk offsets and their scaled products, the
// decision value and the output register.
// ----------------------------------------------------------------------------
module mer_datapath #(
    parameter int COORD_BITS = mer_pkg::COORD_BITS_DEF,
    parameter int AXIS_BITS  = mer_pkg::AXIS_BITS_DEF,
    parameter int CFG_W      = (COORD_BITS > AXIS_BITS) ? COORD_BITS : AXIS_BITS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [mer_pkg::CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [CFG_W-1:0]                i_cfg_wdata,
    input  mer_pkg::t_dp_cmd                i_cmd,
    output mer_pkg::t_dp_status             o_status,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [mer_pkg::OUT_TDATA_W-1:0] o_out_data,
    output logic                            o_out_user,
    output logic                            o_out_last
);

    localparam int OFF_W = AXIS_BITS + 1;
    localparam int SQ_W  = 2 * AXIS_BITS + 2;
    localparam int P_W   = SQ_W + OFF_W;
    localparam int D_W   = 4 * AXIS_BITS;
    localparam int M_W   = 2 * AXIS_BITS + 4;
    localparam int EXT_W = mer_pkg::OUT_W + COORD_BITS + OFF_W;
    localparam int OW    = mer_pkg::OUT_W;

    logic [COORD_BITS-1:0] r_center_x, r_center_y;
    logic [AXIS_BITS-1:0]  r_semi_x, r_semi_y;

    logic [OFF_W-1:0]      r_x, r_y;
    logic [P_W-1:0]        r_px, r_py;
    logic [2*AXIS_BITS-1:0] r_a2, r_b2;
    logic [SQ_W-1:0]       r_a4, r_b4;
    logic [D_W-1:0]        r_ab4, r_t1, r_t2, r_dec;
    logic [2*M_W-1:0]      r_prod;

    logic [M_W-1:0]        mul_a, mul_b;
    logic [OFF_W:0]        tx;
    logic [OFF_W-1:0]      ty_mag;
    logic [D_W-1:0]        prod_d;
    logic [D_W-1:0]        px_d, py_d, a4_d, b4_d, inc;
    logic                  dec_neg, dec_pos, step_x, step_y;

    logic                  r_out_valid;
    logic [OW-1:0]         r_right_x, r_left_x, r_lower_y, r_upper_y;
    logic                  r_out_user, r_out_last;
    logic [EXT_W-1:0]      cx_e, cy_e, x_e, y_e, right_e, left_e, lower_e, upper_e;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center_x <= '0;
            r_center_y <= '0;
            r_semi_x   <= '0;
            r_semi_y   <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                mer_pkg::CFG_CENTER_X:    r_center_x <= i_cfg_wdata[COORD_BITS-1:0];
                mer_pkg::CFG_CENTER_Y:    r_center_y <= i_cfg_wdata[COORD_BITS-1:0];
                mer_pkg::CFG_SEMI_AXIS_X: r_semi_x   <= i_cfg_wdata[AXIS_BITS-1:0];
                mer_pkg::CFG_SEMI_AXIS_Y: r_semi_y   <= i_cfg_wdata[AXIS_BITS-1:0];
            endcase
        end
    end

    // y - 1 is squared on entry to region two; at y = 0 its square is 1.
    assign tx     = {r_x, 1'b1};
    assign ty_mag = (r_y == '0) ? OFF_W'(1) : (r_y - 1'b1);

    always_comb begin
        unique case (i_cmd.op)
            mer_pkg::MUL_AA: begin
                mul_a = M_W'(r_semi_x);
                mul_b = M_W'(r_semi_x);
            end
            mer_pkg::MUL_BB: begin
                mul_a = M_W'(r_semi_y);
                mul_b = M_W'(r_semi_y);
            end
            mer_pkg::MUL_A4B: begin
                mul_a = M_W'(r_a4);
                mul_b = M_W'(r_semi_y);
            end
            mer_pkg::MUL_A4B2: begin
                mul_a = M_W'(r_a4);
                mul_b = M_W'(r_b2);
            end
            mer_pkg::MUL_TXTX: begin
                mul_a = M_W'(tx);
                mul_b = M_W'(tx);
            end
            mer_pkg::MUL_TYTY: begin
                mul_a = M_W'(ty_mag);
                mul_b = M_W'(ty_mag);
            end
            mer_pkg::MUL_B2TX2: begin
                mul_a = M_W'(r_b2);
                mul_b = r_t1[M_W-1:0];
            end
            mer_pkg::MUL_A4TY2: begin
                mul_a = M_W'(r_a4);
                mul_b = r_t2[M_W-1:0];
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_issue) begin
            r_prod <= mul_a * mul_b;
        end
    end

    assign prod_d = r_prod[D_W-1:0];

    // Step arithmetic: px tracks 4b^2*x by addition, py 4a^2*y by subtraction.
    always_comb begin
        px_d    = D_W'(r_px);
        py_d    = D_W'(r_py);
        a4_d    = D_W'(r_a4);
        b4_d    = D_W'(r_b4);
        dec_neg = r_dec[D_W-1];
        dec_pos = !dec_neg && (r_dec != '0);
        if (!i_cmd.region_two) begin
            step_x = 1'b1;
            step_y = !dec_neg;
            inc    = (px_d << 1) + b4_d + (b4_d << 1);
            if (!dec_neg) begin
                inc = inc - (py_d << 1) + (a4_d << 1);
            end
        end else begin
            step_x = !dec_pos;
            step_y = (r_y != '0);
            inc    = a4_d + (a4_d << 1) - (py_d << 1);
            if (!dec_pos) begin
                inc = inc + (px_d << 1) + (b4_d << 1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.seed) begin
            r_x  <= '0;
            r_y  <= OFF_W'(r_semi_y);
            r_px <= '0;
        end
        if (i_cmd.mul_wb) begin
            unique case (i_cmd.op)
                mer_pkg::MUL_AA: begin
                    r_a2 <= prod_d[2*AXIS_BITS-1:0];
                    r_a4 <= {prod_d[2*AXIS_BITS-1:0], 2'b00};
                end
                mer_pkg::MUL_BB: begin
                    r_b2 <= prod_d[2*AXIS_BITS-1:0];
                    r_b4 <= {prod_d[2*AXIS_BITS-1:0], 2'b00};
                end
                mer_pkg::MUL_A4B: begin
                    r_py  <= prod_d[P_W-1:0];
                    r_dec <= D_W'(r_b4) - prod_d + D_W'(r_a2);
                end
                mer_pkg::MUL_A4B2:  r_ab4 <= prod_d;
                mer_pkg::MUL_TXTX:  r_t1  <= prod_d;
                mer_pkg::MUL_TYTY:  r_t2  <= prod_d;
                mer_pkg::MUL_B2TX2: r_t1  <= prod_d;
                mer_pkg::MUL_A4TY2: r_dec <= r_t1 + prod_d - r_ab4;
            endcase
        end
        if (i_cmd.emit) begin
            r_dec <= r_dec + inc;
            if (step_x) begin
                r_x  <= r_x + 1'b1;
                r_px <= r_px + P_W'(r_b4);
            end
            if (step_y) begin
                r_y  <= r_y - 1'b1;
                r_py <= r_py - P_W'(r_a4);
            end
        end
    end

    assign cx_e    = EXT_W'(r_center_x);
    assign cy_e    = EXT_W'(r_center_y);
    assign x_e     = EXT_W'(r_x);
    assign y_e     = EXT_W'(r_y);
    assign right_e = cx_e + x_e;
    assign left_e  = cx_e - x_e;
    assign lower_e = cy_e + y_e;
    assign upper_e = cy_e - y_e;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_right_x  <= right_e[OW-1:0];
            r_left_x   <= left_e[OW-1:0];
            r_lower_y  <= lower_e[OW-1:0];
            r_upper_y  <= upper_e[OW-1:0];
            r_out_user <= i_cmd.region_two;
            r_out_last <= i_cmd.region_two && (r_y == '0);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = mer_pkg::OUT_TDATA_W'({r_upper_y, r_lower_y, r_left_x, r_right_x});
    assign o_out_user  = r_out_user;
    assign o_out_last  = r_out_last;

    assign o_status.py_gt_px = (r_py > r_px);
    assign o_status.y_zero   = (r_y == '0);
    assign o_status.out_free = !r_out_valid || i_out_ready;

endmodule

@@ sv/midpoint_ellipse_rasterizer_unit.sv @@
// ----------------------------------------------------------------------------
// midpoint_ellipse_rasterizer_unit: two-region midpoint ellipse walker
// Each input word either reseeds the walk from the configuration and steps,
// or advances it by one step, giving the four mirrored quadrant points.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake                   Contents
//  s_axis    in         tvalid / tready             tdata[0] restart
//  m_axis    out        tvalid / tready             tdata four points, tuser
//                                                   region two, tlast final
//  cfg       in         write enable, no stall      index, write data
//
// After a step without restart is accepted, the controller checks the
// phase, then emits and updates, and then returns to the ready state,
// where the next word can be accepted.
// A restart first runs the seed, four multiplications through the
// shared multiplier, each issued and then written back.
// The step that enters region two runs four more on the same multiplier
// to recompute the decision value. A step with nothing to give skips emit.
// The emit cycle waits while the output register holds a word that is not
// being taken; the input side then stays stalled. Reset clears the
// configuration registers, the controller state, phase and multiplier
// operation, and the output valid flag only.
//
module midpoint_ellipse_rasterizer_unit #(
    parameter int COORD_BITS = mer_pkg::COORD_BITS_DEF,
    parameter int AXIS_BITS  = mer_pkg::AXIS_BITS_DEF,
    parameter int CFG_W      = (COORD_BITS > AXIS_BITS) ? COORD_BITS : AXIS_BITS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Configuration: center_x, center_y, semi_axis_x, semi_axis_y at 0..3.
    input  logic                            i_cfg_we,
    input  logic [mer_pkg::CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [CFG_W-1:0]                i_cfg_wdata,
    // Input words.
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // Fields from bit 0: restart, then zero padding.
    input  logic [mer_pkg::IN_TDATA_W-1:0]  i_s_axis_tdata,
    // Result words.
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // Fields from bit 0: right_x, left_x, lower_y, upper_y, then zero padding.
    output logic [mer_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata,
    // Fields from bit 0: in_second_region.
    output logic [0:0]                      o_m_axis_tuser,
    // last_point: the final point, at a vertical offset of zero.
    output logic                            o_m_axis_tlast
);

    mer_pkg::t_dp_cmd    cmd;
    mer_pkg::t_dp_status status;
    logic                out_user;

    // The controller owns the walk phase and the step sequence; the
    // datapath only acts on its commands and reports comparisons.
    mer_controller u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_restart  (i_s_axis_tdata[0]),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    mer_datapath #(
        .COORD_BITS (COORD_BITS),
        .AXIS_BITS  (AXIS_BITS),
        .CFG_W      (CFG_W)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_out_data  (o_m_axis_tdata),
        .o_out_user  (out_user),
        .o_out_last  (o_m_axis_tlast)
    );

    assign o_m_axis_tuser = out_user;

endmodule

@@ sv/mer_checker.sv @@
// ----------------------------------------------------------------------------
// mer_checker: port-level checks for the ellipse rasteriser
// Watches the stream ports over time and is bound to the top level.
// ----------------------------------------------------------------------------
module mer_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_s_axis_tvalid,
    input logic                            i_s_axis_tready,
    input logic                            i_m_axis_tvalid,
    input logic                            i_m_axis_tready,
    input logic [mer_pkg::OUT_TDATA_W-1:0] i_m_axis_tdata,
    input logic [0:0]                      i_m_axis_tuser,
    input logic                            i_m_axis_tlast
);

    localparam int OW = mer_pkg::OUT_W;

    // A stalled result word holds.
    a_out_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_axis_tvalid && !i_m_axis_tready |=>
            i_m_axis_tvalid && $stable(i_m_axis_tdata))
        else $error("result word changed while stalled");

    // One word is worked on at a time: no acceptance straight after another.
    a_one_at_a_time : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && i_s_axis_tready |=> !i_s_axis_tready)
        else $error("input accepted on consecutive cycles");

    // The final point belongs to region two and lies on the horizontal axis.
    a_last_point : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_axis_tvalid && i_m_axis_tlast |->
            i_m_axis_tuser[0] &&
            (i_m_axis_tdata[3*OW-1:2*OW] == i_m_axis_tdata[4*OW-1:3*OW]))
        else $error("final point outside region two or off the axis");

    // Mirrored coordinates differ by twice an offset, so their parity agrees.
    a_mirror_parity : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_axis_tvalid |->
            (i_m_axis_tdata[0] == i_m_axis_tdata[OW]) &&
            (i_m_axis_tdata[2*OW] == i_m_axis_tdata[3*OW]))
        else $error("mirrored points are not symmetric about the center");

endmodule

bind midpoint_ellipse_rasterizer_unit mer_checker u_mer_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .i_s_axis_tready (o_s_axis_tready),
    .i_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .i_m_axis_tdata  (o_m_axis_tdata),
    .i_m_axis_tuser  (o_m_axis_tuser),
    .i_m_axis_tlast  (o_m_axis_tlast)
);

@@ test/midpoint_ellipse_rasterizer_unit_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// midpoint_ellipse_rasterizer_unit_tb: self-checking bench for the ellipse walker
// Streams restart and step words into the rasteriser and checks every point
// against a cycle-free model of the two-region walk. Both stream sides idle
// and stall at random. The registers are reprogrammed between phases.
// ----------------------------------------------------------------------------
module midpoint_ellipse_rasterizer_unit_tb;

    // Register write data is as wide as the widest register.
    localparam int CFG_W = (mer_pkg::COORD_BITS_DEF > mer_pkg::AXIS_BITS_DEF) ?
                           mer_pkg::COORD_BITS_DEF : mer_pkg::AXIS_BITS_DEF;
    localparam int unsigned RANDOM_WORDS   = 1200;
    localparam int unsigned HOLDOFF_CYCLES = 400;
    localparam int unsigned SETTLE_CYCLES  = 16;
    localparam int unsigned END_CYCLES     = 40;
    localparam int unsigned WATCHDOG_LIMIT = 5000;
    localparam int unsigned MAX_COORD      = 2047;
    localparam int unsigned MAX_AXIS       = 1023;

    // Where the walk stands between steps.
    typedef enum logic [1:0] {
        WALK_IDLE,
        WALK_REGION_ONE,
        WALK_REGION_TWO,
        WALK_DONE
    } t_walk_phase;

    // How the result side paces its ready line outside the long hold-off.
    typedef enum logic [1:0] {
        RX_STEADY,
        RX_COIN,
        RX_SPARSE
    } t_rx_mode;

    // One plotted step: the four mirrored coordinates and the two flags.
    typedef struct {
        logic [12:0] right_x;
        logic [12:0] left_x;
        logic [12:0] lower_y;
        logic [12:0] upper_y;
        logic        second_region;
        logic        last_point;
    } t_ellipse_point;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            i_cfg_we = 1'b0;
    logic [mer_pkg::CFG_ADDR_W-1:0]  i_cfg_addr = '0;
    logic [CFG_W-1:0]                i_cfg_wdata = '0;
    logic                            i_s_axis_tvalid = 1'b0;
    logic                            o_s_axis_tready;
    // Fields from bit 0: restart, then zero padding.
    logic [mer_pkg::IN_TDATA_W-1:0]  i_s_axis_tdata = '0;
    logic                            o_m_axis_tvalid;
    logic                            i_m_axis_tready = 1'b0;
    // Fields from bit 0: right_x, left_x, lower_y, upper_y, then zero padding.
    logic [mer_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata;
    // Fields from bit 0: in_second_region.
    logic [0:0]                      o_m_axis_tuser;
    logic                            o_m_axis_tlast;

    midpoint_ellipse_rasterizer_unit uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Shadow of the register file and of the walk. The shadow registers only
    // change while the block is quiet, so the walk model can read them at the
    // moment a word is accepted.
    // ------------------------------------------------------------------------
    logic [10:0] shadow_center_x = '0;
    logic [10:0] shadow_center_y = '0;
    logic [9:0]  shadow_semi_x = '0;
    logic [9:0]  shadow_semi_y = '0;

    // All walk arithmetic is done modulo 2^64, so the decision value is a
    // two's complement number whose sign is bit 63.
    t_walk_phase walk_phase = WALK_IDLE;
    logic [63:0] walk_x = '0;
    logic [63:0] walk_y = '0;
    logic [63:0] walk_decision = '0;
    logic [63:0] walk_four_a_sq = '0;
    logic [63:0] walk_four_b_sq = '0;

    t_ellipse_point expected_points[$];
    bit             pending_restart_flags[$];

    int unsigned points_predicted = 0;
    int unsigned points_checked = 0;
    int unsigned restarts_seen = 0;
    int unsigned region_two_points = 0;
    int unsigned last_points_seen = 0;
    int unsigned words_accepted = 0;
    int unsigned words_queued = 0;
    int unsigned mismatch_count = 0;

    // Advances the walk by one accepted word and queues the point it plots,
    // if any. A restart reseeds from the registers before stepping.
    task automatic walk_ellipse_step(input logic restart);
        logic [63:0] semi_a;
        logic [63:0] semi_b;
        logic [63:0] tx;
        logic [63:0] ty;
        logic [63:0] step_inc;
        t_ellipse_point pt;
        if (restart) begin
            semi_a = 64'(shadow_semi_x);
            semi_b = 64'(shadow_semi_y);
            walk_four_a_sq = 64'd4 * semi_a * semi_a;
            walk_four_b_sq = 64'd4 * semi_b * semi_b;
            walk_x = '0;
            walk_y = semi_b;
            // Four times b^2 - a^2 b + a^2 / 4, so no fraction is left.
            walk_decision = walk_four_b_sq - walk_four_a_sq * semi_b + semi_a * semi_a;
            walk_phase = WALK_REGION_ONE;
            restarts_seen++;
        end
        if (walk_phase == WALK_IDLE || walk_phase == WALK_DONE) begin
            return;
        end

        // Region one ends once the slope passes minus one; the decision value
        // is then recomputed from the current offsets.
        if (walk_phase == WALK_REGION_ONE &&
            !(walk_four_a_sq * walk_y > walk_four_b_sq * walk_x)) begin
            tx = 64'd2 * walk_x + 64'd1;
            ty = walk_y - 64'd1;
            walk_phase = WALK_REGION_TWO;
            walk_decision = (walk_four_b_sq >> 2) * tx * tx + walk_four_a_sq * ty * ty
                            - walk_four_a_sq * (walk_four_b_sq >> 2);
        end

        pt.right_x       = 13'(64'(shadow_center_x) + walk_x);
        pt.left_x        = 13'(64'(shadow_center_x) - walk_x);
        pt.lower_y       = 13'(64'(shadow_center_y) + walk_y);
        pt.upper_y       = 13'(64'(shadow_center_y) - walk_y);
        pt.second_region = (walk_phase == WALK_REGION_TWO);
        pt.last_point    = (walk_phase == WALK_REGION_TWO) && (walk_y == 64'd0);
        expected_points.push_back(pt);
        points_predicted++;

        if (walk_phase == WALK_REGION_ONE) begin
            step_inc = walk_four_b_sq * (64'd2 * walk_x + 64'd3);
            if (walk_decision[63]) begin
                walk_decision = walk_decision + step_inc;
            end else begin
                walk_decision = walk_decision + step_inc
                                - walk_four_a_sq * (64'd2 * walk_y - 64'd2);
                walk_y = walk_y - 64'd1;
            end
            walk_x = walk_x + 64'd1;
        end else begin
            step_inc = 64'd3 * walk_four_a_sq - 64'd2 * walk_four_a_sq * walk_y;
            if (!walk_decision[63] && walk_decision != 64'd0) begin
                walk_decision = walk_decision + step_inc;
            end else begin
                walk_decision = walk_decision + step_inc
                                + walk_four_b_sq * (64'd2 * walk_x + 64'd2);
                walk_x = walk_x + 64'd1;
            end
            if (walk_y == 64'd0) begin
                walk_phase = WALK_DONE;
            end else begin
                walk_y = walk_y - 64'd1;
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Input driver. Words leave the pending queue in bursts of random length
    // separated by random gaps; about half the bursts have no gap at all.
    // word_offered tracks the held word in step with the queue pop, so the
    // stimulus can tell reliably when everything has gone in.
    // ------------------------------------------------------------------------
    int unsigned burst_left = 0;
    int unsigned gap_left = 0;
    bit          word_offered = 1'b0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
            i_s_axis_tdata  <= '0;
        end else begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                words_accepted++;
                word_offered = 1'b0;
                walk_ellipse_step(i_s_axis_tdata[0]);
            end
            if (!i_s_axis_tvalid || o_s_axis_tready) begin
                if (gap_left != 0) begin
                    gap_left--;
                    i_s_axis_tvalid <= 1'b0;
                end else if (pending_restart_flags.size() != 0) begin
                    word_offered = 1'b1;
                    i_s_axis_tvalid <= 1'b1;
                    i_s_axis_tdata  <= {{(mer_pkg::IN_TDATA_W - 1){1'b0}},
                                        pending_restart_flags.pop_front()};
                    if (burst_left != 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 40);
                        gap_left   = $urandom_range(0, 1) ? 0 : $urandom_range(1, 6);
                    end
                end else begin
                    i_s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result side pacing. The ready line switches between steady, coin-toss
    // and sparse modes every so often. Once armed, it holds off for a long
    // stretch so that the output register fills and the input side stalls.
    // ------------------------------------------------------------------------
    t_rx_mode    rx_mode = RX_STEADY;
    int unsigned rx_mode_cycles = 0;
    int unsigned holdoff_left = 0;
    logic        holdoff_armed = 1'b0;
    logic        holdoff_started = 1'b0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else if (holdoff_armed && !holdoff_started) begin
            holdoff_started <= 1'b1;
            holdoff_left    <= HOLDOFF_CYCLES;
            i_m_axis_tready <= 1'b0;
        end else if (holdoff_left != 0) begin
            holdoff_left    <= holdoff_left - 1;
            i_m_axis_tready <= 1'b0;
        end else begin
            if (rx_mode_cycles == 0) begin
                rx_mode        <= t_rx_mode'($urandom_range(0, 2));
                rx_mode_cycles <= $urandom_range(16, 160);
            end else begin
                rx_mode_cycles <= rx_mode_cycles - 1;
            end
            case (rx_mode)
                RX_STEADY: i_m_axis_tready <= 1'b1;
                RX_COIN:   i_m_axis_tready <= 1'($urandom_range(0, 1));
                default:   i_m_axis_tready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Output monitor: every accepted word is checked against the oldest
    // expected point, field by field.
    // ------------------------------------------------------------------------
    t_ellipse_point oldest_point;

    function automatic void compare_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (expected_points.size() == 0) begin
                $error("result word with no expected point: tdata 0x%h", o_m_axis_tdata);
                mismatch_count++;
            end else begin
                oldest_point = expected_points.pop_front();
                compare_field("right_x", $signed(oldest_point.right_x),
                              $signed(o_m_axis_tdata[12:0]));
                compare_field("left_x", $signed(oldest_point.left_x),
                              $signed(o_m_axis_tdata[25:13]));
                compare_field("lower_y", $signed(oldest_point.lower_y),
                              $signed(o_m_axis_tdata[38:26]));
                compare_field("upper_y", $signed(oldest_point.upper_y),
                              $signed(o_m_axis_tdata[51:39]));
                compare_field("in_second_region", oldest_point.second_region,
                              o_m_axis_tuser[0]);
                compare_field("last_point", oldest_point.last_point, o_m_axis_tlast);
                points_checked++;
                if (o_m_axis_tuser[0]) region_two_points++;
                if (o_m_axis_tlast) last_points_seen++;
            end
        end
    end

    // Watchdog: a long run of cycles with no word moving on either side
    // means the block has hung.
    int unsigned quiet_cycles = 0;

    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Timeout: no word moved for %0d cycles, %0d points outstanding.",
                     quiet_cycles, expected_points.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------------

    // Waits until every queued word has gone in and every point has come out,
    // then lets a step that plots nothing finish inside the block.
    task automatic wait_for_quiet();
        while (pending_restart_flags.size() != 0 || word_offered ||
               expected_points.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Writes all four registers on consecutive edges; the write enable stays
    // high across them and drops after the last.
    task automatic write_ellipse_registers(input int unsigned cx, input int unsigned cy,
                                           input int unsigned ax, input int unsigned ay);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= mer_pkg::CFG_CENTER_X;
        i_cfg_wdata <= CFG_W'(cx);
        @(posedge i_clk);
        i_cfg_addr  <= mer_pkg::CFG_CENTER_Y;
        i_cfg_wdata <= CFG_W'(cy);
        @(posedge i_clk);
        i_cfg_addr  <= mer_pkg::CFG_SEMI_AXIS_X;
        i_cfg_wdata <= CFG_W'(ax);
        @(posedge i_clk);
        i_cfg_addr  <= mer_pkg::CFG_SEMI_AXIS_Y;
        i_cfg_wdata <= CFG_W'(ay);
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        shadow_center_x = 11'(cx);
        shadow_center_y = 11'(cy);
        shadow_semi_x   = 10'(ax);
        shadow_semi_y   = 10'(ay);
    endtask

    // A restart word followed by a number of plain steps.
    task automatic queue_walk(input int unsigned steps);
        pending_restart_flags.push_back(1'b1);
        repeat (steps) pending_restart_flags.push_back(1'b0);
        words_queued += steps + 1;
    endtask

    task automatic queue_plain_steps(input int unsigned steps);
        repeat (steps) pending_restart_flags.push_back(1'b0);
        words_queued += steps;
    endtask

    // Centre coordinates lean towards the two ends of the range.
    function automatic int unsigned pick_centre();
        int unsigned sel;
        sel = $urandom_range(0, 7);
        if (sel == 0) return 0;
        if (sel == 1) return MAX_COORD;
        return $urandom_range(0, MAX_COORD);
    endfunction

    // ------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------
    int unsigned cx, cy, ax, ay;
    int unsigned walk_len, steps, walks, kind, sel;
    int unsigned phase_count = 0;
    int unsigned random_base;

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part. Registers hold their reset values first: a step
        // before any restart plots nothing, and a restart with both semi-axes
        // at zero gives a single final point, after which steps are ignored.
        queue_plain_steps(1);
        queue_walk(1);
        wait_for_quiet();

        // Small ellipse at the top corner of the coordinate range, walked to
        // the end and a little beyond.
        write_ellipse_registers(MAX_COORD, MAX_COORD, 3, 2);
        queue_walk(6);
        wait_for_quiet();

        // Zero width: a vertical line walked in region two only, with the
        // upper coordinate going negative.
        write_ellipse_registers(0, 0, 0, 4);
        queue_walk(5);
        wait_for_quiet();

        // Largest semi-axes near both ends of the range, with a restart in
        // the middle of a walk.
        write_ellipse_registers(5, MAX_COORD - 7, MAX_AXIS, MAX_AXIS);
        queue_walk(3);
        queue_walk(2);
        wait_for_quiet();

        // Zero height: the first point is already the last one.
        write_ellipse_registers(MAX_COORD, 0, 4, 0);
        queue_walk(1);
        wait_for_quiet();

        // Random part: each phase reprograms the registers and runs a few
        // walks. Most walks run to their end, some are cut short by the
        // next restart, and a few stray steps are thrown in between.
        random_base = words_queued;
        while (words_queued - random_base < RANDOM_WORDS) begin
            cx  = pick_centre();
            cy  = pick_centre();
            sel = $urandom_range(0, 9);
            if (sel < 7) begin
                ax = $urandom_range(0, 15);
                ay = $urandom_range(0, 15);
            end else if (sel < 9) begin
                ax = $urandom_range(0, 40);
                ay = $urandom_range(16, 40);
            end else begin
                ax = $urandom_range(0, 1) ? MAX_AXIS : $urandom_range(41, MAX_AXIS);
                ay = $urandom_range(0, 1) ? MAX_AXIS : $urandom_range(0, MAX_AXIS);
            end
            write_ellipse_registers(cx, cy, ax, ay);

            // The long hold-off on the result side comes early in the run.
            if (phase_count == 2) holdoff_armed <= 1'b1;

            walk_len = ax + ay + 1;
            walks = $urandom_range(2, 5);
            repeat (walks) begin
                kind = $urandom_range(0, 19);
                if (kind < 15) begin
                    steps = (walk_len > 90) ? $urandom_range(5, 40)
                                            : walk_len + $urandom_range(0, 2);
                    queue_walk(steps);
                end else if (kind < 18) begin
                    steps = $urandom_range(0, (walk_len > 40) ? 40 : walk_len);
                    queue_walk(steps);
                end else begin
                    queue_plain_steps($urandom_range(1, 3));
                end
            end
            wait_for_quiet();
            phase_count++;
        end

        repeat (END_CYCLES) @(posedge i_clk);

        $display("Run covered %0d input words over %0d register settings, %0d restarts.",
                 words_accepted, phase_count + 5, restarts_seen);
        $display("Checked %0d points, %0d in region two and %0d final points.",
                 points_checked, region_two_points, last_points_seen);
        if (mismatch_count == 0 && expected_points.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

@@ files.f @@
sv/mer_pkg.sv
sv/mer_controller.sv
sv/mer_datapath.sv
sv/midpoint_ellipse_rasterizer_unit.sv
sv/mer_checker.sv
test/midpoint_ellipse_rasterizer_unit_tb.sv
